[hw/rtl/imlc_pkg.sv]
`timescale 1ns / 1ps

package imlc_pkg;

	localparam int COUNT_BITS = 20;
	localparam int NUM_CAT    = 9;
	localparam int BYTE_W     = 8;
	localparam int LINE_W     = 20;
	localparam int TOTAL_W    = 24;
	localparam int CYC_W      = 30;
	localparam int WEIGHT_W   = 8;
	localparam int CFG_IDX_W  = 2;

	// category positions in the flag vector
	localparam int CAT_ADD  = 0;
	localparam int CAT_SUB  = 1;
	localparam int CAT_MUL  = 2;
	localparam int CAT_DIV  = 3;
	localparam int CAT_MOV  = 4;
	localparam int CAT_LEA  = 5;
	localparam int CAT_PUSH = 6;
	localparam int CAT_POP  = 7;
	localparam int CAT_RET  = 8;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MUL_WEIGHT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_DIV_WEIGHT = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_RET_WEIGHT = CFG_IDX_W'(2);

	localparam logic [WEIGHT_W-1:0] MUL_WEIGHT_RST = WEIGHT_W'(4);
	localparam logic [WEIGHT_W-1:0] DIV_WEIGHT_RST = WEIGHT_W'(15);
	localparam logic [WEIGHT_W-1:0] RET_WEIGHT_RST = WEIGHT_W'(3);

	localparam logic [BYTE_W-1:0] NEWLINE = BYTE_W'(10);

	typedef struct packed {
		logic [NUM_CAT-1:0] flags;
		logic               last;
	} commit_t;

	typedef struct packed {
		logic [NUM_CAT-1:0][LINE_W-1:0] lines;
		logic [TOTAL_W-1:0]             total;
		logic [CYC_W-1:0]               cycles;
	} report_t;

	function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] r;
		r = b;
		if (b >= "A" && b <= "Z") begin
			r = b + BYTE_W'(32);
		end
		return r;
	endfunction

	// w0 oldest, w4 newest; all bytes already folded
	function automatic logic [NUM_CAT-1:0] match_window(
		input logic [BYTE_W-1:0] w0,
		input logic [BYTE_W-1:0] w1,
		input logic [BYTE_W-1:0] w2,
		input logic [BYTE_W-1:0] w3,
		input logic [BYTE_W-1:0] w4
	);
		logic [NUM_CAT-1:0] f;
		logic [23:0]        stem;
		logic [31:0]        stem4;
		logic               sq, sl, sw, sb;
		stem  = {w1, w2, w3};
		stem4 = {w0, w1, w2, w3};
		sq    = (w4 == "q");
		sl    = (w4 == "l");
		sw    = (w4 == "w");
		sb    = (w4 == "b");
		f           = '0;
		f[CAT_ADD]  = (stem == "add") && (sq || sl || sb);
		f[CAT_SUB]  = (stem == "sub") && (sq || sl);
		f[CAT_MUL]  = (stem == "mul") && (sq || sl);
		f[CAT_DIV]  = (stem == "div") && (sq || sb || sw || sl);
		f[CAT_MOV]  = (stem == "mov") && (sq || sl || sw || sb);
		f[CAT_LEA]  = (stem == "lea") && (sq || sl);
		f[CAT_PUSH] = (stem4 == "push") && (sq || sl);
		f[CAT_POP]  = (stem == "pop") && (sq || sl || sw || sb);
		f[CAT_RET]  = (stem == "ret") && sq;
		return f;
	endfunction

endpackage

[hw/rtl/imlc_queue.sv]
`timescale 1ns / 1ps

module imlc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  imlc_pkg::commit_t wr_item,
	output logic             full,
	input  logic             rd_en,
	output imlc_pkg::commit_t rd_item,
	output logic             empty
);
	import imlc_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = PTR_W + 1;

	commit_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_wr;
	logic               do_rd;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

[hw/rtl/imlc_front.sv]
`timescale 1ns / 1ps

module imlc_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [imlc_pkg::BYTE_W-1:0]  text_byte,
	input  logic                         end_of_text,
	output logic                         cq_push,
	output imlc_pkg::commit_t            cq_item,
	input  logic                         cq_full
);
	import imlc_pkg::*;

	logic [BYTE_W-1:0]  win_q [4];
	logic [NUM_CAT-1:0] flags_q;
	logic [BYTE_W-1:0]  folded;
	logic [NUM_CAT-1:0] flags_next;
	logic               accept;
	logic               is_nl;

	assign full       = cq_full;
	assign accept     = push && !cq_full;
	assign is_nl      = (text_byte == NEWLINE);
	assign folded     = fold_case(text_byte);
	assign flags_next = flags_q | match_window(win_q[0], win_q[1], win_q[2], win_q[3], folded);

	// a line ends on a newline or on the last byte of the text
	assign cq_push       = accept && (is_nl || end_of_text);
	assign cq_item.flags = is_nl ? flags_q : flags_next;
	assign cq_item.last  = end_of_text;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				win_q[i] <= '0;
			end
			flags_q <= '0;
		end else if (accept) begin
			if (is_nl || end_of_text) begin
				for (int i = 0; i < 4; i++) begin
					win_q[i] <= '0;
				end
				flags_q <= '0;
			end else begin
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= win_q[3];
				win_q[3] <= folded;
				flags_q  <= flags_next;
			end
		end
	end

endmodule

[hw/rtl/imlc_back.sv]
`timescale 1ns / 1ps

module imlc_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cq_empty,
	input  imlc_pkg::commit_t              cq_item,
	output logic                           cq_pop,
	input  logic                           cfg_valid,
	input  logic [imlc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [imlc_pkg::WEIGHT_W-1:0]  cfg_data,
	output logic                           empty,
	input  logic                           pop,
	output imlc_pkg::report_t              rpt
);
	import imlc_pkg::*;

	localparam int SUM_W  = COUNT_BITS + 4;
	localparam int PROD_W = COUNT_BITS + WEIGHT_W;
	localparam int ACC_W  = COUNT_BITS + 10;
	localparam int ODEPTH = 4;
	localparam int OPTR_W = $clog2(ODEPTH);
	localparam int OCNT_W = OPTR_W + 1;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic [WEIGHT_W-1:0]   mul_w_q;
	logic [WEIGHT_W-1:0]   div_w_q;
	logic [WEIGHT_W-1:0]   ret_w_q;

	logic [COUNT_BITS-1:0] cnt_q    [NUM_CAT];
	logic [COUNT_BITS-1:0] cnt_next [NUM_CAT];

	logic                  v_s1;
	logic [COUNT_BITS-1:0] cnt_s1 [NUM_CAT];

	logic                           v_s2;
	logic [NUM_CAT-1:0][LINE_W-1:0] lines_s2;
	logic [TOTAL_W-1:0]             total_s2;
	logic [SUM_W-1:0]               other_s2;
	logic [PROD_W-1:0]              pmul_s2;
	logic [PROD_W-1:0]              pdiv_s2;
	logic [PROD_W-1:0]              pret_s2;

	logic [SUM_W-1:0]  sum_all;
	logic [SUM_W-1:0]  sum_other;
	logic [ACC_W-1:0]  weighted;
	report_t           rpt_in;

	report_t           oq_mem_q [ODEPTH];
	logic [OPTR_W-1:0] oq_wr_q;
	logic [OPTR_W-1:0] oq_rd_q;
	logic [OCNT_W-1:0] oq_cnt_q;
	logic [OCNT_W-1:0] oq_used;
	logic              credit;
	logic              oq_pop;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_w_q <= MUL_WEIGHT_RST;
			div_w_q <= DIV_WEIGHT_RST;
			ret_w_q <= RET_WEIGHT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MUL_WEIGHT: mul_w_q <= cfg_data;
				CFG_DIV_WEIGHT: div_w_q <= cfg_data;
				CFG_RET_WEIGHT: ret_w_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a report needs a free output slot, counting reports still in flight
	assign oq_used = oq_cnt_q + OCNT_W'(v_s1) + OCNT_W'(v_s2);
	assign credit  = (oq_used < OCNT_W'(ODEPTH));
	assign cq_pop  = !cq_empty && (!cq_item.last || credit);

	always_comb begin
		for (int c = 0; c < NUM_CAT; c++) begin
			if (cq_item.flags[c] && (cnt_q[c] != CNT_MAX)) begin
				cnt_next[c] = cnt_q[c] + COUNT_BITS'(1);
			end else begin
				cnt_next[c] = cnt_q[c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CAT; c++) begin
				cnt_q[c] <= '0;
			end
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cq_pop && cq_item.last;
			v_s2 <= v_s1;
			if (cq_pop) begin
				for (int c = 0; c < NUM_CAT; c++) begin
					cnt_q[c] <= cq_item.last ? '0 : cnt_next[c];
				end
			end
		end
	end

	// stage 1: snapshot of the final counts
	always_ff @(posedge clk) begin
		if (cq_pop && cq_item.last) begin
			for (int c = 0; c < NUM_CAT; c++) begin
				cnt_s1[c] <= cnt_next[c];
			end
		end
	end

	always_comb begin
		sum_all   = '0;
		sum_other = '0;
		for (int c = 0; c < NUM_CAT; c++) begin
			sum_all = sum_all + SUM_W'(cnt_s1[c]);
			if (c != CAT_MUL && c != CAT_DIV && c != CAT_RET) begin
				sum_other = sum_other + SUM_W'(cnt_s1[c]);
			end
		end
	end

	// stage 2: products and sums
	always_ff @(posedge clk) begin
		if (v_s1) begin
			for (int c = 0; c < NUM_CAT; c++) begin
				lines_s2[c] <= LINE_W'(cnt_s1[c]);
			end
			total_s2 <= TOTAL_W'(sum_all);
			other_s2 <= sum_other;
			pmul_s2  <= PROD_W'(cnt_s1[CAT_MUL]) * PROD_W'(mul_w_q);
			pdiv_s2  <= PROD_W'(cnt_s1[CAT_DIV]) * PROD_W'(div_w_q);
			pret_s2  <= PROD_W'(cnt_s1[CAT_RET]) * PROD_W'(ret_w_q);
		end
	end

	assign weighted = ACC_W'(other_s2) + ACC_W'(pmul_s2) + ACC_W'(pdiv_s2) + ACC_W'(pret_s2);

	always_comb begin
		rpt_in.lines  = lines_s2;
		rpt_in.total  = total_s2;
		rpt_in.cycles = CYC_W'(weighted);
	end

	// result queue
	assign empty  = (oq_cnt_q == '0);
	assign oq_pop = pop && !empty;
	assign rpt    = oq_mem_q[oq_rd_q];

	always_ff @(posedge clk) begin
		if (v_s2) begin
			oq_mem_q[oq_wr_q] <= rpt_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (v_s2) begin
				oq_wr_q <= oq_wr_q + OPTR_W'(1);
			end
			if (oq_pop) begin
				oq_rd_q <= oq_rd_q + OPTR_W'(1);
			end
			if (v_s2 && !oq_pop) begin
				oq_cnt_q <= oq_cnt_q + OCNT_W'(1);
			end else if (oq_pop && !v_s2) begin
				oq_cnt_q <= oq_cnt_q - OCNT_W'(1);
			end
		end
	end

endmodule

[hw/rtl/instruction_mnemonic_line_counter_top.sv]
// a report passes the 4-entry commit queue, stage 1, stage 2 and the 4-entry result queue
// throughput: one text byte per cycle while not full; line commits drain one per cycle
// unless a report waits for a free slot in the result queue, counting reports in flight
// reset (arst_n low): window, line flags and counters clear, weights return to 4, 15, 3
`timescale 1ns / 1ps

module instruction_mnemonic_line_counter_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [imlc_pkg::BYTE_W-1:0]    text_byte,
	input  logic                           end_of_text,
	output logic                           empty,
	input  logic                           pop,
	output logic [imlc_pkg::LINE_W-1:0]    add_lines,
	output logic [imlc_pkg::LINE_W-1:0]    sub_lines,
	output logic [imlc_pkg::LINE_W-1:0]    mul_lines,
	output logic [imlc_pkg::LINE_W-1:0]    div_lines,
	output logic [imlc_pkg::LINE_W-1:0]    mov_lines,
	output logic [imlc_pkg::LINE_W-1:0]    lea_lines,
	output logic [imlc_pkg::LINE_W-1:0]    push_lines,
	output logic [imlc_pkg::LINE_W-1:0]    pop_lines,
	output logic [imlc_pkg::LINE_W-1:0]    ret_lines,
	output logic [imlc_pkg::TOTAL_W-1:0]   total_count,
	output logic [imlc_pkg::CYC_W-1:0]     weighted_cycles,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [imlc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [imlc_pkg::WEIGHT_W-1:0]  cfg_data
);
	import imlc_pkg::*;

	logic    cq_push;
	logic    cq_full;
	logic    cq_pop;
	logic    cq_empty;
	commit_t cq_wr_item;
	commit_t cq_rd_item;
	report_t rpt;

	assign cfg_ready = 1'b1;

	imlc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.cq_push     (cq_push),
		.cq_item     (cq_wr_item),
		.cq_full     (cq_full)
	);

	imlc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cq_push),
		.wr_item (cq_wr_item),
		.full    (cq_full),
		.rd_en   (cq_pop),
		.rd_item (cq_rd_item),
		.empty   (cq_empty)
	);

	imlc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cq_empty  (cq_empty),
		.cq_item   (cq_rd_item),
		.cq_pop    (cq_pop),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.empty     (empty),
		.pop       (pop),
		.rpt       (rpt)
	);

	assign add_lines       = rpt.lines[CAT_ADD];
	assign sub_lines       = rpt.lines[CAT_SUB];
	assign mul_lines       = rpt.lines[CAT_MUL];
	assign div_lines       = rpt.lines[CAT_DIV];
	assign mov_lines       = rpt.lines[CAT_MOV];
	assign lea_lines       = rpt.lines[CAT_LEA];
	assign push_lines      = rpt.lines[CAT_PUSH];
	assign pop_lines       = rpt.lines[CAT_POP];
	assign ret_lines       = rpt.lines[CAT_RET];
	assign total_count     = rpt.total;
	assign weighted_cycles = rpt.cycles;

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cq_full |-> !cq_push)
		else $error("line commit pushed into a full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cq_empty |-> !cq_pop)
		else $error("line commit popped from an empty queue");

	a_last_reaches_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && end_of_text) |=> !cq_empty)
		else $error("final line commit missing from queue");

endmodule

[tb/sv/tb_instruction_mnemonic_line_counter_top.sv]
`timescale 1ns / 1ps

module tb_instruction_mnemonic_line_counter_top;
	import imlc_pkg::*;

	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_SETTLE = 12;
	localparam int N_MNEMONICS  = 24;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 push        = 1'b0;
	logic                 full;
	logic [BYTE_W-1:0]    text_byte   = '0;
	logic                 end_of_text = 1'b0;
	logic                 empty;
	logic                 pop         = 1'b0;
	logic [LINE_W-1:0]    add_lines, sub_lines, mul_lines, div_lines, mov_lines;
	logic [LINE_W-1:0]    lea_lines, push_lines, pop_lines, ret_lines;
	logic [TOTAL_W-1:0]   total_count;
	logic [CYC_W-1:0]     weighted_cycles;
	logic                 cfg_valid   = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index   = '0;
	logic [WEIGHT_W-1:0]  cfg_data    = '0;

	wire [NUM_CAT-1:0][LINE_W-1:0] port_lines = {ret_lines, pop_lines, push_lines,
		lea_lines, mov_lines, div_lines, mul_lines, sub_lines, add_lines};

	// predictor state
	logic [5*BYTE_W-1:0] text_window = '0;
	logic [NUM_CAT-1:0]  line_flags  = '0;
	logic [LINE_W-1:0]   line_counts [NUM_CAT];
	logic [WEIGHT_W-1:0] mul_weight  = MUL_WEIGHT_RST;
	logic [WEIGHT_W-1:0] div_weight  = DIV_WEIGHT_RST;
	logic [WEIGHT_W-1:0] ret_weight  = RET_WEIGHT_RST;
	report_t             expected_reports [$];

	int mismatch_count  = 0;
	int reports_checked = 0;
	int quiet_cycles    = 0;
	int src_idle_pct    = 34;
	int sink_idle_pct   = 34;
	int pop_hold        = 0;

	string line_field_names [NUM_CAT] = '{"add_lines", "sub_lines", "mul_lines",
		"div_lines", "mov_lines", "lea_lines", "push_lines", "pop_lines", "ret_lines"};
	string mnemonic_words [N_MNEMONICS] = '{"addq", "addl", "addb", "subq", "subl",
		"mulq", "mull", "divq", "divb", "divw", "divl", "movq", "movl", "movw", "movb",
		"leaq", "leal", "pushq", "pushl", "popq", "popl", "popw", "popb", "retq"};
	string near_chars = "abdeilmopqrstuvwxADMQ 0,%";

	instruction_mnemonic_line_counter_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.text_byte      (text_byte),
		.end_of_text    (end_of_text),
		.empty          (empty),
		.pop            (pop),
		.add_lines      (add_lines),
		.sub_lines      (sub_lines),
		.mul_lines      (mul_lines),
		.div_lines      (div_lines),
		.mov_lines      (mov_lines),
		.lea_lines      (lea_lines),
		.push_lines     (push_lines),
		.pop_lines      (pop_lines),
		.ret_lines      (ret_lines),
		.total_count    (total_count),
		.weighted_cycles(weighted_cycles),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #5 clk = ~clk;

	initial begin
		for (int c = 0; c < NUM_CAT; c++) begin
			line_counts[c] = '0;
		end
	end

	// window holds the last five folded bytes, oldest in the top byte
	function automatic logic [NUM_CAT-1:0] mnemonic_hits(input logic [5*BYTE_W-1:0] w);
		logic [NUM_CAT-1:0] hits;
		hits = '0;
		case (w[31:0])
			"addq", "addl", "addb":         hits[CAT_ADD] = 1'b1;
			"subq", "subl":                 hits[CAT_SUB] = 1'b1;
			"mulq", "mull":                 hits[CAT_MUL] = 1'b1;
			"divq", "divb", "divw", "divl": hits[CAT_DIV] = 1'b1;
			"movq", "movl", "movw", "movb": hits[CAT_MOV] = 1'b1;
			"leaq", "leal":                 hits[CAT_LEA] = 1'b1;
			"popq", "popl", "popw", "popb": hits[CAT_POP] = 1'b1;
			"retq":                         hits[CAT_RET] = 1'b1;
			default: ;
		endcase
		if (w == "pushq" || w == "pushl") begin
			hits[CAT_PUSH] = 1'b1;
		end
		return hits;
	endfunction

	task automatic close_line();
		for (int c = 0; c < NUM_CAT; c++) begin
			if (line_flags[c] && line_counts[c] != '1) begin
				line_counts[c] = line_counts[c] + 1'b1;
			end
		end
		text_window = '0;
		line_flags  = '0;
	endtask

	task automatic model_text_byte(input logic [BYTE_W-1:0] b, input logic last);
		logic [BYTE_W-1:0]   folded;
		logic [WEIGHT_W-1:0] w;
		longint              sum;
		longint              cyc;
		report_t             r;
		if (b == NEWLINE) begin
			close_line();
		end else begin
			folded      = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
			text_window = {text_window[4*BYTE_W-1:0], folded};
			line_flags  = line_flags | mnemonic_hits(text_window);
			if (last) begin
				close_line();
			end
		end
		if (last) begin
			sum = 0;
			cyc = 0;
			for (int c = 0; c < NUM_CAT; c++) begin
				w = (c == CAT_MUL) ? mul_weight : (c == CAT_DIV) ? div_weight :
					(c == CAT_RET) ? ret_weight : 8'd1;
				r.lines[c] = line_counts[c];
				sum += longint'(line_counts[c]);
				cyc += longint'(line_counts[c]) * longint'(w);
				line_counts[c] = '0;
			end
			r.total  = sum[TOTAL_W-1:0];
			r.cycles = cyc[CYC_W-1:0];
			expected_reports.push_back(r);
			text_window = '0;
			line_flags  = '0;
		end
	endtask

	task automatic check_field(input string field, input longint want, input longint got);
		if (want != got) begin
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("report %0d: %s expected %0d, got %0d", reports_checked, field,
					want, got);
			end
		end
	endtask

	// predicts on every input transfer, checks every result transfer
	always @(posedge clk) begin : monitor
		report_t want;
		if (arst_n) begin
			quiet_cycles++;
			if (cfg_valid && cfg_ready) begin
				quiet_cycles = 0;
				case (cfg_index)
					CFG_MUL_WEIGHT: mul_weight = cfg_data;
					CFG_DIV_WEIGHT: div_weight = cfg_data;
					CFG_RET_WEIGHT: ret_weight = cfg_data;
					default: ;
				endcase
			end
			if (push && !full) begin
				quiet_cycles = 0;
				model_text_byte(text_byte, end_of_text);
			end
			if (pop && !empty) begin
				quiet_cycles = 0;
				reports_checked++;
				if (expected_reports.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("report %0d arrived with none outstanding", reports_checked);
					end
				end else begin
					want = expected_reports.pop_front();
					for (int c = 0; c < NUM_CAT; c++) begin
						check_field(line_field_names[c], want.lines[c], port_lines[c]);
					end
					check_field("total_count", want.total, total_count);
					check_field("weighted_cycles", want.cycles, weighted_cycles);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (pop_hold > 0) begin
			pop      <= 1'b0;
			pop_hold = pop_hold - 1;
		end else begin
			pop <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("Mismatches found");
		$finish;
	end

	task automatic send_text_byte(input logic [BYTE_W-1:0] b, input logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push        <= 1'b1;
		text_byte   <= b;
		end_of_text <= last;
		do @(posedge clk); while (full);
	endtask

	task automatic send_text(input string s, input logic last);
		for (int i = 0; i < s.len(); i++) begin
			send_text_byte(s[i], last && (i == s.len() - 1));
		end
	endtask

	function automatic logic [BYTE_W-1:0] random_case(input logic [BYTE_W-1:0] b);
		if (b >= "a" && b <= "z" && $urandom_range(3) == 0) begin
			return b - 8'd32;
		end
		return b;
	endfunction

	function automatic logic [WEIGHT_W-1:0] random_weight();
		if ($urandom_range(3) == 0) begin
			return $urandom_range(1) ? 8'hFF : 8'h00;
		end
		return 8'($urandom_range(255));
	endfunction

	// lines of whole mnemonics, fragments, near-miss letters and raw bytes
	task automatic send_random_text(input int max_lines, input int min_len, input int max_len);
		logic [BYTE_W-1:0] text_q [$];
		logic              tail_newline;
		int                n_lines;
		int                len;
		int                line_start;
		int                pick;
		int                cut;
		string             m;
		n_lines      = $urandom_range(max_lines, 1);
		tail_newline = 1'($urandom_range(1));
		for (int ln = 0; ln < n_lines; ln++) begin
			len        = $urandom_range(max_len, min_len);
			line_start = text_q.size();
			while (text_q.size() - line_start < len) begin
				pick = $urandom_range(99);
				if (pick < 45) begin
					m   = mnemonic_words[$urandom_range(N_MNEMONICS - 1)];
					cut = (pick < 35) ? m.len() : $urandom_range(m.len() - 1, 1);
					for (int i = 0; i < cut; i++) begin
						text_q.push_back(random_case(m[i]));
					end
				end else if (pick < 85) begin
					text_q.push_back(random_case(near_chars[$urandom_range(near_chars.len() - 1)]));
				end else begin
					text_q.push_back(8'($urandom_range(255)));
				end
			end
			if (ln < n_lines - 1 || tail_newline) begin
				text_q.push_back(NEWLINE);
			end
		end
		if (text_q.size() == 0) begin
			text_q.push_back(NEWLINE);
		end
		for (int i = 0; i < text_q.size(); i++) begin
			send_text_byte(text_q[i], i == text_q.size() - 1);
		end
	endtask

	task automatic wait_for_reports();
		@(negedge clk);
		push <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_SETTLE) @(posedge clk);
	endtask

	task automatic write_weight(input logic [CFG_IDX_W-1:0] idx, input logic [WEIGHT_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all_weights(input logic [WEIGHT_W-1:0] wm, input logic [WEIGHT_W-1:0] wd,
		input logic [WEIGHT_W-1:0] wr);
		wait_for_reports();
		write_weight(CFG_MUL_WEIGHT, wm);
		write_weight(CFG_DIV_WEIGHT, wd);
		write_weight(CFG_RET_WEIGHT, wr);
	endtask

	// zero and all-ones bytes mid line, newline as last byte, unterminated last line
	task automatic test_directed_lines();
		send_text("ADDq", 1'b0);
		send_text_byte(8'h00, 1'b0);
		send_text("Pushl", 1'b0);
		send_text_byte(8'hFF, 1'b0);
		send_text("retq", 1'b0);
		send_text_byte(NEWLINE, 1'b1);
		send_text("mOvw", 1'b1);
		send_text_byte(NEWLINE, 1'b1);
		wait_for_reports();
	endtask

	task automatic test_result_backpressure();
		pop_hold = 160;
		repeat (12) send_text("retq", 1'b1);
		wait_for_reports();
	endtask

	task automatic test_weight_extremes();
		write_all_weights(8'h00, 8'h00, 8'h00);
		repeat (2) send_random_text(2, 4, 10);
		write_all_weights(8'hFF, 8'hFF, 8'hFF);
		repeat (2) send_random_text(2, 4, 10);
		wait_for_reports();
		write_weight(CFG_UNUSED_INDEX, 8'h5A);
		repeat (2) send_random_text(2, 4, 10);
		wait_for_reports();
	endtask

	task automatic test_long_line();
		send_random_text(1, 250, 254);
		wait_for_reports();
	endtask

	task automatic test_back_to_back();
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		repeat (5) send_random_text(2, 1, 10);
		wait_for_reports();
		src_idle_pct  = 34;
		sink_idle_pct = 34;
	endtask

	task automatic test_random_texts();
		repeat (2) begin
			write_all_weights(random_weight(), random_weight(), random_weight());
			repeat (2) send_random_text(3, 0, 10);
		end
		wait_for_reports();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_lines();
		test_result_backpressure();
		test_weight_extremes();
		test_long_line();
		test_back_to_back();
		test_random_texts();
		wait_for_reports();
		if (mismatch_count == 0 && expected_reports.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
